[rtl/core/lpp_pkg.sv]
`timescale 1ns / 1ps
package lpp_pkg;

	localparam int COEF_FRAC_BITS = 12;
	localparam int PIXEL_BITS     = 16;
	localparam int DEN_W          = 48;
	localparam int MAG_W          = 64;
	localparam int REM_W          = DEN_W + PIXEL_BITS;

	localparam logic [2:0] REG_ROW_DEPTH = 3'd0;
	localparam logic [2:0] REG_ROW_HORIZ = 3'd1;
	localparam logic [2:0] REG_ROW_VERT  = 3'd2;
	localparam logic [2:0] REG_FOCAL_U   = 3'd3;
	localparam logic [2:0] REG_CENTER_U  = 3'd4;
	localparam logic [2:0] REG_FOCAL_V   = 3'd5;
	localparam logic [2:0] REG_CENTER_V  = 3'd6;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_DROP  = 2'd1;
	localparam logic [1:0] STAT_DEPTH = 2'd2;

	localparam logic signed [31:0] FOCAL_U_RST  = -32'sd142827616;
	localparam logic signed [31:0] CENTER_U_RST = 32'sd36077126;
	localparam logic signed [31:0] FOCAL_V_RST  = -32'sd153941664;
	localparam logic signed [31:0] CENTER_V_RST = 32'sd48695974;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [PIXEL_BITS-1:0] pixel_u;
		logic signed [PIXEL_BITS-1:0] pixel_v;
		logic [1:0]                   proj_status;
	} pixel_t;

	typedef struct packed {
		logic [1:0] status;
		logic       neg_u;
		logic       neg_v;
	} div_side_t;

	typedef struct packed {
		logic [MAG_W-1:0] mag_u;
		logic [MAG_W-1:0] mag_v;
		logic [DEN_W-1:0] den;
		div_side_t        side;
	} div_in_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] q_u;
		logic [PIXEL_BITS-1:0] q_v;
		logic [DEN_W-1:0]      rem_u;
		logic [DEN_W-1:0]      rem_v;
		logic                  ovf_u;
		logic                  ovf_v;
		logic [DEN_W-1:0]      den;
		div_side_t             side;
	} div_out_t;

	function automatic logic signed [PIXEL_BITS-1:0] round_sat(
		input logic [PIXEL_BITS-1:0] q,
		input logic [DEN_W-1:0]      rem,
		input logic [DEN_W-1:0]      den,
		input logic                  ovf,
		input logic                  neg
	);
		logic [DEN_W:0]        r2;
		logic [DEN_W:0]        dx;
		logic                  up;
		logic [PIXEL_BITS:0]   qr;
		logic [PIXEL_BITS:0]   qn;
		logic [PIXEL_BITS:0]   pos_max;
		logic [PIXEL_BITS:0]   neg_max;
		logic signed [PIXEL_BITS-1:0] res;
		r2      = {rem, 1'b0};
		dx      = {1'b0, den};
		up      = (r2 > dx) || ((r2 == dx) && q[0]);
		qr      = {1'b0, q} + {{PIXEL_BITS{1'b0}}, up};
		qn      = ~qr + {{PIXEL_BITS{1'b0}}, 1'b1};
		pos_max = {2'b00, {(PIXEL_BITS-1){1'b1}}};
		neg_max = {2'b01, {(PIXEL_BITS-1){1'b0}}};
		if (!neg) begin
			if (ovf || (qr > pos_max))
				res = {1'b0, {(PIXEL_BITS-1){1'b1}}};
			else
				res = qr[PIXEL_BITS-1:0];
		end else begin
			if (ovf || (qr > neg_max))
				res = {1'b1, {(PIXEL_BITS-1){1'b0}}};
			else
				res = qn[PIXEL_BITS-1:0];
		end
		return res;
	endfunction

endpackage

[rtl/core/lpp_div.sv]
`timescale 1ns / 1ps
module lpp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lpp_pkg::div_in_t  in_word,
	output logic              out_valid,
	input  logic              out_ready,
	output lpp_pkg::div_out_t out_word
);

	localparam int PB = lpp_pkg::PIXEL_BITS;
	localparam int RW = lpp_pkg::REM_W;
	localparam int DW = lpp_pkg::DEN_W;
	localparam int MW = lpp_pkg::MAG_W;

	logic [PB:0]    v_s;
	logic [PB+1:0]  en;
	logic [RW-1:0]  rem_u_s [0:PB];
	logic [RW-1:0]  rem_v_s [0:PB];
	logic [PB-1:0]  q_u_s   [0:PB];
	logic [PB-1:0]  q_v_s   [0:PB];
	logic [DW-1:0]  den_s   [0:PB];
	logic [PB:0]    ovf_u_s;
	logic [PB:0]    ovf_v_s;
	lpp_pkg::div_side_t side_s [0:PB];

	logic             ovf_u_in;
	logic             ovf_v_in;

	assign en[PB+1] = out_ready;
	assign in_ready = en[0];

	genvar g;
	generate
		for (g = 0; g <= PB; g++) begin : g_en
			assign en[g] = !v_s[g] || en[g+1];
		end
	endgenerate

	assign ovf_u_in = {{PB{1'b0}}, in_word.mag_u[MW-1:PB]} >= MW'(in_word.den);
	assign ovf_v_in = {{PB{1'b0}}, in_word.mag_v[MW-1:PB]} >= MW'(in_word.den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en[0])
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en[0] && in_valid) begin
			ovf_u_s[0] <= ovf_u_in;
			ovf_v_s[0] <= ovf_v_in;
			rem_u_s[0] <= ovf_u_in ? '0 : RW'(in_word.mag_u);
			rem_v_s[0] <= ovf_v_in ? '0 : RW'(in_word.mag_v);
			q_u_s[0]   <= '0;
			q_v_s[0]   <= '0;
			den_s[0]   <= in_word.den;
			side_s[0]  <= in_word.side;
		end
	end

	generate
		for (g = 1; g <= PB; g++) begin : g_bit
			logic [RW-1:0] trial;
			logic          ge_u;
			logic          ge_v;

			assign trial = RW'(den_s[g-1]) << (PB - g);
			assign ge_u  = rem_u_s[g-1] >= trial;
			assign ge_v  = rem_v_s[g-1] >= trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					v_s[g] <= 1'b0;
				else if (en[g])
					v_s[g] <= v_s[g-1];
			end

			always_ff @(posedge clk) begin
				if (en[g] && v_s[g-1]) begin
					rem_u_s[g] <= ge_u ? rem_u_s[g-1] - trial : rem_u_s[g-1];
					rem_v_s[g] <= ge_v ? rem_v_s[g-1] - trial : rem_v_s[g-1];
					q_u_s[g]   <= {q_u_s[g-1][PB-2:0], ge_u};
					q_v_s[g]   <= {q_v_s[g-1][PB-2:0], ge_v};
					ovf_u_s[g] <= ovf_u_s[g-1];
					ovf_v_s[g] <= ovf_v_s[g-1];
					den_s[g]   <= den_s[g-1];
					side_s[g]  <= side_s[g-1];
				end
			end
		end
	endgenerate

	assign out_valid      = v_s[PB];
	assign out_word.q_u   = q_u_s[PB];
	assign out_word.q_v   = q_v_s[PB];
	assign out_word.rem_u = rem_u_s[PB][DW-1:0];
	assign out_word.rem_v = rem_v_s[PB][DW-1:0];
	assign out_word.ovf_u = ovf_u_s[PB];
	assign out_word.ovf_v = ovf_v_s[PB];
	assign out_word.den   = den_s[PB];
	assign out_word.side  = side_s[PB];

	a_rem_u_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ovf_u_s[PB] |-> rem_u_s[PB] < RW'(den_s[PB]))
		else $error("remainder u not below divisor");

	a_rem_v_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ovf_v_s[PB] |-> rem_v_s[PB] < RW'(den_s[PB]))
		else $error("remainder v not below divisor");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

endmodule

[rtl/core/lidar_point_to_pixel_projection.sv]
`timescale 1ns / 1ps
// channel   | signals                          | word
// point     | point_valid, point_ready, point  | point_x, point_y, point_z (Q16.16)
// pixel     | pixel_valid, pixel_ready, pixel  | pixel_u, pixel_v, proj_status
// cfg       | cfg_we, cfg_idx, cfg_wdata       | register index 0..6, 64-bit data
//
// One point per cycle while the pixel output is not stalled; a one-bit-per-stage
// restoring divider follows the transform and focal multipliers.
// Reset clears every valid bit and loads the intrinsic defaults; rows reset to 0.
// Each stage advances when its successor is empty or advancing, so bubbles
// fill while the output word is held and a stall loses nothing.
module lidar_point_to_pixel_projection (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            point_valid,
	output logic            point_ready,
	input  lpp_pkg::point_t point,
	output logic            pixel_valid,
	input  logic            pixel_ready,
	output lpp_pkg::pixel_t pixel,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_idx,
	input  logic [63:0]     cfg_wdata
);

	localparam int CFB = lpp_pkg::COEF_FRAC_BITS;
	localparam logic signed [49:0] C32_MAX = 50'sd2147483647;
	localparam logic signed [49:0] C32_MIN = -50'sd2147483648;

	logic [63:0]        row_q [0:2];
	logic signed [31:0] focal_u_q;
	logic signed [31:0] center_u_q;
	logic signed [31:0] focal_v_q;
	logic signed [31:0] center_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= '0;
			row_q[1]   <= '0;
			row_q[2]   <= '0;
			focal_u_q  <= lpp_pkg::FOCAL_U_RST;
			center_u_q <= lpp_pkg::CENTER_U_RST;
			focal_v_q  <= lpp_pkg::FOCAL_V_RST;
			center_v_q <= lpp_pkg::CENTER_V_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				lpp_pkg::REG_ROW_DEPTH: row_q[0]   <= cfg_wdata;
				lpp_pkg::REG_ROW_HORIZ: row_q[1]   <= cfg_wdata;
				lpp_pkg::REG_ROW_VERT:  row_q[2]   <= cfg_wdata;
				lpp_pkg::REG_FOCAL_U:   focal_u_q  <= cfg_wdata[31:0];
				lpp_pkg::REG_CENTER_U:  center_u_q <= cfg_wdata[31:0];
				lpp_pkg::REG_FOCAL_V:   focal_v_q  <= cfg_wdata[31:0];
				lpp_pkg::REG_CENTER_V:  center_v_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	logic en1, en2, en3, en4, en5, en_out;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic div_in_ready, div_out_valid;
	lpp_pkg::div_in_t  div_in;
	lpp_pkg::div_out_t div_out;

	assign en_out      = !pixel_valid || pixel_ready;
	assign en5         = !v_s5 || div_in_ready;
	assign en4         = !v_s4 || en5;
	assign en3         = !v_s3 || en4;
	assign en2         = !v_s2 || en3;
	assign en1         = !v_s1 || en2;
	assign point_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= point_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: coefficient products
	logic signed [47:0] prod_s1 [0:2][0:2];
	logic signed [15:0] off_s1  [0:2];
	logic               drop_s1;

	always_ff @(posedge clk) begin
		if (en1 && point_valid) begin
			drop_s1 <= point.point_x[31];
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= $signed(row_q[r][15:0])  * point.point_x;
				prod_s1[r][1] <= $signed(row_q[r][31:16]) * point.point_y;
				prod_s1[r][2] <= $signed(row_q[r][47:32]) * point.point_z;
				off_s1[r]     <= $signed(row_q[r][63:48]);
			end
		end
	end

	// stage 2: row sums, floor shift, saturate
	logic signed [49:0] sum_c [0:2];
	logic signed [49:0] shr_c [0:2];
	logic signed [31:0] cam_c [0:2];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum_c[r] = {{2{prod_s1[r][0][47]}}, prod_s1[r][0]}
			         + {{2{prod_s1[r][1][47]}}, prod_s1[r][1]}
			         + {{2{prod_s1[r][2][47]}}, prod_s1[r][2]}
			         + {{18{off_s1[r][15]}}, off_s1[r], 16'b0};
			shr_c[r] = sum_c[r] >>> CFB;
			if (shr_c[r] > C32_MAX)
				cam_c[r] = C32_MAX[31:0];
			else if (shr_c[r] < C32_MIN)
				cam_c[r] = C32_MIN[31:0];
			else
				cam_c[r] = shr_c[r][31:0];
		end
	end

	logic signed [31:0] cam_s2 [0:2];
	logic               drop_s2;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			drop_s2 <= drop_s1;
			for (int r = 0; r < 3; r++)
				cam_s2[r] <= cam_c[r];
		end
	end

	// stage 3: focal and center products
	logic signed [63:0] fq_u_s3, cd_u_s3, fq_v_s3, cd_v_s3;
	logic [31:0]        dx_s3;
	logic [1:0]         stat_s3;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			fq_u_s3 <= focal_u_q * cam_s2[1];
			cd_u_s3 <= center_u_q * cam_s2[0];
			fq_v_s3 <= focal_v_q * cam_s2[2];
			cd_v_s3 <= center_v_q * cam_s2[0];
			dx_s3   <= cam_s2[0];
			if (drop_s2)
				stat_s3 <= lpp_pkg::STAT_DROP;
			else if (cam_s2[0] <= 32'sd0)
				stat_s3 <= lpp_pkg::STAT_DEPTH;
			else
				stat_s3 <= lpp_pkg::STAT_OK;
		end
	end

	// stage 4: numerators
	logic [64:0] num_u_s4, num_v_s4;
	logic [31:0] dx_s4;
	logic [1:0]  stat_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			num_u_s4 <= {fq_u_s3[63], fq_u_s3} + {cd_u_s3[63], cd_u_s3};
			num_v_s4 <= {fq_v_s3[63], fq_v_s3} + {cd_v_s3[63], cd_v_s3};
			dx_s4    <= dx_s3;
			stat_s4  <= stat_s3;
		end
	end

	// stage 5: magnitudes and divisor
	logic [64:0] abs_u_c, abs_v_c;
	assign abs_u_c = num_u_s4[64] ? 65'd0 - num_u_s4 : num_u_s4;
	assign abs_v_c = num_v_s4[64] ? 65'd0 - num_v_s4 : num_v_s4;

	lpp_pkg::div_in_t div_in_s5;

	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			div_in_s5.mag_u       <= abs_u_c[63:0];
			div_in_s5.mag_v       <= abs_v_c[63:0];
			div_in_s5.den         <= {dx_s4, 16'b0};
			div_in_s5.side.status <= stat_s4;
			div_in_s5.side.neg_u  <= num_u_s4[64];
			div_in_s5.side.neg_v  <= num_v_s4[64];
		end
	end

	assign div_in = div_in_s5;

	lpp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_ready  (div_in_ready),
		.in_word   (div_in),
		.out_valid (div_out_valid),
		.out_ready (en_out),
		.out_word  (div_out)
	);

	// output register: round, saturate, clear on bad status
	logic            pixel_valid_q;
	lpp_pkg::pixel_t pixel_q;
	lpp_pkg::pixel_t pixel_c;

	always_comb begin
		pixel_c.proj_status = div_out.side.status;
		if (div_out.side.status == lpp_pkg::STAT_OK) begin
			pixel_c.pixel_u = lpp_pkg::round_sat(div_out.q_u, div_out.rem_u,
				div_out.den, div_out.ovf_u, div_out.side.neg_u);
			pixel_c.pixel_v = lpp_pkg::round_sat(div_out.q_v, div_out.rem_v,
				div_out.den, div_out.ovf_v, div_out.side.neg_v);
		end else begin
			pixel_c.pixel_u = '0;
			pixel_c.pixel_v = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pixel_valid_q <= 1'b0;
		else if (en_out)
			pixel_valid_q <= div_out_valid;
	end

	always_ff @(posedge clk) begin
		if (en_out && div_out_valid)
			pixel_q <= pixel_c;
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

	a_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && (pixel.proj_status != lpp_pkg::STAT_OK)
		|-> (pixel.pixel_u == '0) && (pixel.pixel_v == '0))
		else $error("pixel not cleared for non-projected point");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_valid |-> point_ready)
		else $error("input stalled with empty output register");

	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		!point_ready |-> pixel_valid && !pixel_ready)
		else $error("input stalled without output backpressure");

endmodule
